/* rtl/mcce_pkg.sv */
// Shared types, codes and constants of the map cell command encoder.
package mcce_pkg;

	// Item function codes
	localparam logic [3:0] FUNC_MULTI     = 4'd0;
	localparam logic [3:0] FUNC_ADJACENT  = 4'd1;
	localparam logic [3:0] FUNC_CAPTIONED = 4'd2;
	localparam logic [3:0] FUNC_CIRCLE    = 4'd3;
	localparam logic [3:0] FUNC_SECTOR    = 4'd4;
	localparam logic [3:0] FUNC_FAT       = 4'd5;
	localparam logic [3:0] FUNC_NULL      = 4'd6;
	localparam logic [3:0] FUNC_LONG_VANE = 4'd7;
	localparam logic [3:0] FUNC_SHORT_VANE = 4'd8;
	localparam logic [3:0] FUNC_END_TILE  = 4'd9;

	// Command stream bytes
	localparam logic [7:0] PRE_LONG     = 8'hF0;
	localparam logic [7:0] PRE_SHORT    = 8'hCF;
	localparam logic [7:0] PRE_CANCEL   = 8'hC0;
	localparam logic [7:0] OP_CIRCLE    = 8'h60;
	localparam logic [7:0] OP_SECTOR    = 8'h40;
	localparam logic [7:0] OP_FAT       = 8'h70;
	localparam logic [7:0] OP_NULL      = 8'hB0;
	localparam logic [7:0] OP_CAPTIONED = 8'h90;
	localparam logic [7:0] OP_ADJACENT  = 8'h80;
	localparam logic [7:0] OP_MULTI     = 8'hA0;
	localparam logic [7:0] OP_SHORT_VANE = 8'h20;
	localparam logic [7:0] OP_END_TILE  = 8'hFF;

	localparam logic [8:0] POS_NONE    = 9'h1FF;
	localparam logic [2:0] CAPTION_MAX = 3'd7;

	// (8*bearing + 45) / 90 as a reciprocal multiply, exact for operands below 10082
	localparam logic [12:0] BEARING_RECIP = 13'd5826;
	localparam int          BEARING_SHIFT = 19;

	localparam int MCCE_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [3:0]         func;
		logic [7:0]         cell_pos;
		logic [3:0]         glyph_size;
		logic [3:0]         colour;
		logic               estimated;
		logic [8:0]         bearing_deg;
		logic signed [31:0] vane_angle;
		logic [2:0]         caption_len;
		logic [55:0]        caption_chars;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_item_t;

	// One classified item: up to four header bytes, then caption bytes
	typedef struct packed {
		logic [3:0][7:0] hdr;
		logic [2:0]      hcnt;
		logic [2:0]      ccnt;
		logic [55:0]     chars;
	} cmd_t;

endpackage

/* rtl/mcce_front.sv */
// Front end: accepts items, tracks tile position state and classifies into byte commands.
module mcce_front import mcce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	input  logic     full,
	output logic     push,
	output cmd_t     cmd
);

	logic [8:0]  last_q;
	logic        any_q;
	logic        take;

	logic [8:0]  pos9;
	logic [8:0]  d;
	logic [8:0]  dm1;
	logic [8:0]  dm2;
	logic [7:0]  rpre0, rpre1, cpre0, cpre1;
	logic [1:0]  rn, cn;
	logic [3:0]  r1;
	logic [12:0] by;
	logic [25:0] bprod;
	logic [4:0]  bsect;
	logic [5:0]  vu;
	logic [4:0]  vcode;
	logic [2:0]  clen;
	logic [7:0]  pre0, pre1, body0, body1;
	logic [1:0]  npre, nbody;

	assign item_ready = !full;
	assign take       = item_valid && item_ready;

	always_comb begin
		pos9 = {1'b0, item.cell_pos};
		if (last_q == POS_NONE) begin
			d = pos9 + 9'd1;
		end else if (pos9 > last_q) begin
			d = pos9 - last_q;
		end else begin
			d = 9'd1;
		end
		dm1 = d - 9'd1;
		dm2 = d - 9'd2;
	end

	// Skip reduced to 1..16 for the opcode nibble
	always_comb begin
		rpre0 = PRE_LONG;
		rpre1 = dm1[7:0];
		rn    = 2'd0;
		r1    = dm1[3:0];
		if (d >= 9'd33) begin
			rn = 2'd2;
			r1 = 4'd0;
		end else if (d >= 9'd17) begin
			rpre0 = PRE_SHORT;
			rn    = 2'd1;
		end
	end

	// Sector items cancel the skip completely
	always_comb begin
		cpre0 = PRE_LONG;
		cpre1 = dm1[7:0];
		cn    = 2'd0;
		if (d > 9'd17) begin
			cn = 2'd2;
		end else if (d >= 9'd2) begin
			cpre0 = PRE_CANCEL | {4'h0, dm2[3:0]};
			cn    = 2'd1;
		end
	end

	always_comb begin
		by    = {1'b0, item.bearing_deg, 3'b000} + 13'd45;
		bprod = {13'd0, by} * {13'd0, BEARING_RECIP};
		bsect = bprod[BEARING_SHIFT +: 5];
		vu    = item.vane_angle[31:26] + 6'd1;
		vcode = vu[5:1];
		clen  = (item.caption_len > CAPTION_MAX) ? CAPTION_MAX : item.caption_len;
	end

	always_comb begin
		pre0  = rpre0;
		pre1  = rpre1;
		npre  = rn;
		body0 = 8'h00;
		body1 = {item.glyph_size, item.colour};
		nbody = 2'd1;
		case (item.func)
			FUNC_MULTI: begin
				body0 = OP_MULTI | {4'h0, r1};
			end
			FUNC_ADJACENT: begin
				body0 = OP_ADJACENT | {4'h0, r1};
				body1 = {item.estimated, 3'b000, item.colour};
				nbody = 2'd2;
			end
			FUNC_CAPTIONED: begin
				body0 = OP_CAPTIONED | {4'h0, r1};
				body1 = {item.estimated, clen, item.colour};
				nbody = 2'd2;
			end
			FUNC_CIRCLE: begin
				body0 = OP_CIRCLE | {4'h0, r1};
				nbody = 2'd2;
			end
			FUNC_SECTOR: begin
				pre0  = cpre0;
				pre1  = cpre1;
				npre  = cn;
				body0 = OP_SECTOR | {3'b000, bsect};
				nbody = 2'd2;
			end
			FUNC_FAT: begin
				body0 = OP_FAT | {4'h0, r1};
				nbody = 2'd2;
			end
			FUNC_NULL: begin
				body0 = OP_NULL | {4'h0, r1};
			end
			FUNC_LONG_VANE: begin
				npre  = 2'd0;
				body0 = {3'b000, vcode};
			end
			FUNC_SHORT_VANE: begin
				npre  = 2'd0;
				body0 = OP_SHORT_VANE | {3'b000, vcode};
			end
			FUNC_END_TILE: begin
				npre  = 2'd0;
				body0 = OP_END_TILE;
				nbody = any_q ? 2'd1 : 2'd0;
			end
			default: begin
				npre  = 2'd0;
				nbody = 2'd0;
			end
		endcase
	end

	always_comb begin
		case (npre)
			2'd1:    cmd.hdr = {8'h00, body1, body0, pre0};
			2'd2:    cmd.hdr = {body1, body0, pre1, pre0};
			default: cmd.hdr = {8'h00, 8'h00, body1, body0};
		endcase
		cmd.hcnt  = {1'b0, npre} + {1'b0, nbody};
		cmd.ccnt  = (item.func == FUNC_CAPTIONED) ? clen : 3'd0;
		cmd.chars = item.caption_chars;
	end

	assign push = take && (cmd.hcnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= POS_NONE;
			any_q  <= 1'b0;
		end else if (take) begin
			if (item.func <= FUNC_NULL) begin
				last_q <= pos9;
				any_q  <= 1'b1;
			end else if (item.func == FUNC_END_TILE) begin
				last_q <= POS_NONE;
				any_q  <= 1'b0;
			end
		end
	end

endmodule

/* rtl/mcce_queue.sv */
// Short command queue between the front and back ends.
module mcce_queue import mcce_pkg::*; #(
	parameter int DEPTH = MCCE_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	output logic head_valid,
	output cmd_t head,
	input  logic pop
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/mcce_back.sv */
// Back end: plays queued commands one byte per free cycle into the output register.
module mcce_back import mcce_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	output logic      code_valid,
	input  logic      code_ready,
	output out_item_t code
);

	cmd_t      work_q;
	cmd_t      cur;
	cmd_t      nxt;
	logic      busy;
	logic      cur_valid;
	logic      slot_free;
	logic      emit;
	logic      valid_q;
	out_item_t code_q;
	out_item_t byte_d;
	logic [3:0] left;

	assign busy      = (work_q.hcnt != 3'd0) || (work_q.ccnt != 3'd0);
	assign cur       = busy ? work_q : head;
	assign cur_valid = busy || head_valid;
	assign slot_free = !valid_q || code_ready;
	assign emit      = slot_free && cur_valid;
	assign pop       = emit && !busy;

	always_comb begin
		left = {1'b0, cur.hcnt} + {1'b0, cur.ccnt};
		nxt  = cur;
		if (cur.hcnt != 3'd0) begin
			byte_d.out_byte = cur.hdr[0];
			nxt.hdr         = {8'h00, cur.hdr[3:1]};
			nxt.hcnt        = cur.hcnt - 3'd1;
		end else begin
			byte_d.out_byte = cur.chars[7:0];
			nxt.chars       = {8'h00, cur.chars[55:8]};
			nxt.ccnt        = cur.ccnt - 3'd1;
		end
		byte_d.last_byte = (left == 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				work_q <= nxt;
			end
			if (slot_free) begin
				valid_q <= cur_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_q <= byte_d;
		end
	end

	assign code_valid = valid_q;
	assign code       = code_q;

endmodule

/* rtl/map_cell_command_encoder.sv */
// Top level of the map cell command encoder.
// Turns the cell records of one tile into a byte command stream. An item is
// taken in any cycle in which the command queue (QUEUE_DEPTH entries) has room,
// so items may follow back to back; the byte port then delivers one byte per
// cycle unless code_ready stalls it. An item has 1 to 4 bytes for cells,
// vanes and end of tile, up to 11 for a captioned tower. The sustained item
// rate is therefore set by the single byte output register. The first byte
// passes through the command queue and then the output register. Items that
// make no bytes (end of tile with nothing coded, unused function codes) are
// taken at the input and never enter the queue.
module map_cell_command_encoder import mcce_pkg::*; #(
	parameter int QUEUE_DEPTH = MCCE_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      code_valid,
	input  logic      code_ready,
	output out_item_t code
);

	logic push, full, head_valid, pop;
	cmd_t cmd, head;

	mcce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.full       (full),
		.push       (push),
		.cmd        (cmd)
	);

	mcce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wdata      (cmd),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	mcce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

endmodule

/* rtl/mcce_checker.sv */
// Port-level checks of the map cell command encoder, bound to the top level.
module mcce_checker import mcce_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_ready,
	input in_item_t  item,
	input logic      code_valid,
	input logic      code_ready,
	input out_item_t code
);

	// Stalled output byte holds
	a_code_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_ready |=> code_valid && $stable(code))
		else $error("output byte changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !code_valid)
		else $error("output valid during reset");

	// Queue can only fill while the output is backed up
	a_ready_when_idle: assert property (@(posedge clk)
		!code_valid |-> item_ready)
		else $error("input stalled with idle output");

	// An item's bytes leave without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_ready && !code.last_byte |=> code_valid)
		else $error("gap inside an item's bytes");

endmodule

bind map_cell_command_encoder mcce_checker u_mcce_checker (.*);

/* tb/sv/map_cell_command_encoder_tb.sv */
// Self-checking testbench for the map cell command encoder.
`timescale 1ns / 100ps

module map_cell_command_encoder_tb;
	import mcce_pkg::*;

	localparam logic [3:0] FUNC_UNUSED_LO = 4'd10;
	localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;
	localparam int ITEM_TARGET = 170;
	localparam int QUIET_AFTER = 140;
	localparam int LONG_HOLD = 300;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_item_t item;
	logic code_valid;
	logic code_ready;
	out_item_t code;

	map_cell_command_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.code_valid(code_valid),
		.code_ready(code_ready),
		.code(code)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// tile state of the predictor
	logic [8:0] tile_last = POS_NONE;
	logic tile_coded = 1'b0;
	logic [7:0] cmd_bytes[$];
	out_item_t exp_stream[$];

	int fails = 0;
	int bytes_checked = 0;
	int items_sent = 0;
	int tiles_sent = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	typedef struct {
		in_item_t it;
		int nexp;
		logic [31:0] word;
	} dir_row_t;

	dir_row_t dir_rows[$];

	function automatic void put_byte(input logic [7:0] v);
		cmd_bytes.push_back(v);
	endfunction

	// Bytes the block should emit for one item; updates the tile state.
	function automatic void encode_cell(input in_item_t it);
		int d;
		int r;
		int b;
		logic [5:0] u;
		cmd_bytes.delete();
		if (it.func <= FUNC_NULL) begin
			if (tile_last == POS_NONE)
				d = it.cell_pos + 1;
			else if ({1'b0, it.cell_pos} > tile_last)
				d = it.cell_pos - tile_last;
			else
				d = 1;
			tile_last = {1'b0, it.cell_pos};
			tile_coded = 1'b1;
			if (it.func == FUNC_SECTOR) begin
				b = ((it.bearing_deg * 32 + 180) / 360) % 32;
				// sector cancels the whole skip
				if (d > 17) begin
					put_byte(PRE_LONG);
					put_byte(8'(d - 1));
				end else if (d >= 2) begin
					put_byte(PRE_CANCEL | 8'(d - 2));
				end
				put_byte(OP_SECTOR | 8'(b));
				put_byte({it.glyph_size, it.colour});
			end else begin
				r = d;
				if (d >= 33) begin
					put_byte(PRE_LONG);
					put_byte(8'(d - 1));
					r = 1;
				end else if (d >= 17) begin
					put_byte(PRE_SHORT);
					r = d - 16;
				end
				case (it.func)
					FUNC_MULTI: begin
						put_byte(OP_MULTI | 8'(r - 1));
					end
					FUNC_ADJACENT: begin
						put_byte(OP_ADJACENT | 8'(r - 1));
						put_byte({it.estimated, 3'b000, it.colour});
					end
					FUNC_CAPTIONED: begin
						put_byte(OP_CAPTIONED | 8'(r - 1));
						put_byte({it.estimated, it.caption_len, it.colour});
						for (int k = 0; k < it.caption_len; k++)
							put_byte(it.caption_chars[8*k +: 8]);
					end
					FUNC_CIRCLE: begin
						put_byte(OP_CIRCLE | 8'(r - 1));
						put_byte({it.glyph_size, it.colour});
					end
					FUNC_FAT: begin
						put_byte(OP_FAT | 8'(r - 1));
						put_byte({it.glyph_size, it.colour});
					end
					default: begin
						put_byte(OP_NULL | 8'(r - 1));
					end
				endcase
			end
		end else if (it.func == FUNC_LONG_VANE || it.func == FUNC_SHORT_VANE) begin
			u = it.vane_angle[31:26] + 6'd1;
			if (it.func == FUNC_LONG_VANE)
				put_byte({3'b000, u[5:1]});
			else
				put_byte(OP_SHORT_VANE | u[5:1]);
		end else if (it.func == FUNC_END_TILE) begin
			if (tile_coded)
				put_byte(OP_END_TILE);
			tile_last = POS_NONE;
			tile_coded = 1'b0;
		end
	endfunction

	function automatic in_item_t mk(input logic [3:0] f, input logic [7:0] pos,
		input logic [3:0] sz, input logic [3:0] col, input logic est,
		input logic [8:0] brg, input logic [31:0] ang, input logic [2:0] clen,
		input logic [55:0] chars);
		in_item_t it;
		it.func = f;
		it.cell_pos = pos;
		it.glyph_size = sz;
		it.colour = col;
		it.estimated = est;
		it.bearing_deg = brg;
		it.vane_angle = ang;
		it.caption_len = clen;
		it.caption_chars = chars;
		return it;
	endfunction

	function automatic in_item_t rand_item(input logic [3:0] f, input logic [7:0] pos);
		logic [8:0] brg;
		logic [63:0] chars;
		brg = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(360, 511))
			: 9'($urandom_range(0, 359));
		chars = {$urandom, $urandom};
		return mk(f, pos, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			1'($urandom_range(0, 1)), brg, $urandom, 3'($urandom_range(0, 7)),
			chars[55:0]);
	endfunction

	task automatic add_row(input in_item_t it, input int n, input logic [31:0] w);
		dir_row_t row;
		row.it = it;
		row.nexp = n;
		row.word = w;
		dir_rows.push_back(row);
	endtask

	// Offer one item and record its bytes once the transfer happens.
	// nexp < 0: bytes come from the predictor, else from word, first byte on top.
	task automatic send(input in_item_t it, input int nexp, input logic [31:0] word);
		out_item_t e;
		int n;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		encode_cell(it);
		n = (nexp < 0) ? cmd_bytes.size() : nexp;
		for (int k = 0; k < n; k++) begin
			e.out_byte = (nexp < 0) ? cmd_bytes[k] : word[31 - 8*k -: 8];
			e.last_byte = (k == n - 1);
			exp_stream.push_back(e);
		end
		if (it.func <= FUNC_END_TILE)
			items_sent++;
		if (it.func == FUNC_END_TILE)
			tiles_sent++;
	endtask

	task automatic random_tile();
		int p;
		int gap;
		int sel;
		int pos;
		p = -1;
		repeat ($urandom_range(1, 10)) begin
			sel = $urandom_range(0, 9);
			if (sel < 3)
				gap = 1;
			else if (sel < 6)
				gap = $urandom_range(2, 16);
			else if (sel < 8)
				gap = $urandom_range(17, 32);
			else
				gap = $urandom_range(33, 255);
			if (p >= 0 && $urandom_range(0, 9) == 0) begin
				pos = $urandom_range(0, p);   // out of order cell
			end else begin
				if (p + gap > 255)
					break;
				pos = p + gap;
				p = pos;
			end
			send(rand_item(4'($urandom_range(FUNC_MULTI, FUNC_NULL)), 8'(pos)), -1, 0);
			if ($urandom_range(0, 3) == 0)
				send(rand_item(4'($urandom_range(FUNC_LONG_VANE, FUNC_SHORT_VANE)),
					8'(pos)), -1, 0);
		end
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 3))
				send(rand_item(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))),
					-1, 0);
		end
		send(rand_item(FUNC_END_TILE, 8'($urandom_range(0, 255))), -1, 0);
	endtask

	// output checker
	always @(posedge clk) begin
		if (arst_n && code_valid && code_ready) begin
			bytes_checked++;
			if (exp_stream.size() == 0) begin
				$error("byte %h with no expectation pending", code.out_byte);
				fails++;
			end else begin
				if (code.out_byte !== exp_stream[0].out_byte) begin
					$error("out_byte: expected %h, got %h", exp_stream[0].out_byte, code.out_byte);
					fails++;
				end
				if (code.last_byte !== exp_stream[0].last_byte) begin
					$error("last_byte: expected %b, got %b", exp_stream[0].last_byte,
						code.last_byte);
					fails++;
				end
				void'(exp_stream.pop_front());
			end
		end
	end

	// byte sink: random stalls, plus one long hold-off so the input backs up
	initial begin
		code_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				code_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				code_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			code_ready <= 1'b1;
		end
	end

	initial begin
		#400000;
		$display("timeout with %0d bytes outstanding", exp_stream.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;

		add_row(mk(FUNC_END_TILE, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(mk(FUNC_MULTI, 0, 0, 0, 0, 0, 0, 0, 0), 1, {OP_MULTI, 24'h0});
		add_row(mk(FUNC_ADJACENT, 1, 0, 4'hF, 1, 0, 0, 0, 0), 2, {OP_ADJACENT, 8'h8F, 16'h0});
		add_row(mk(FUNC_CAPTIONED, 3, 0, 5, 0, 0, 0, 7, 56'hFF_00_41_7E_80_01_5A), -1, 0);
		add_row(mk(FUNC_CIRCLE, 20, 4'hF, 0, 1, 0, 0, 0, 0), -1, 0);
		add_row(mk(FUNC_FAT, 52, 4'h3, 4'hC, 0, 0, 0, 0, 0), -1, 0);
		add_row(mk(FUNC_SECTOR, 53, 0, 0, 0, 0, 0, 0, 0), 2, {OP_SECTOR, 24'h0});
		add_row(mk(FUNC_SECTOR, 55, 4'h9, 4'h6, 0, 359, 0, 0, 0), -1, 0);
		add_row(mk(FUNC_SECTOR, 73, 4'hF, 4'hF, 1, 511, 0, 0, 0), -1, 0);
		add_row(mk(FUNC_SECTOR, 90, 4'h1, 4'h2, 0, 180, 0, 0, 0), -1, 0);
		add_row(mk(FUNC_NULL, 150, 0, 0, 0, 0, 0, 0, 0), -1, 0);
		add_row(mk(FUNC_NULL, 150, 0, 0, 0, 0, 0, 0, 0), 1, {OP_NULL, 24'h0});
		add_row(mk(FUNC_MULTI, 10, 0, 0, 0, 0, 0, 0, 0), 1, {OP_MULTI, 24'h0});
		add_row(mk(FUNC_CAPTIONED, 11, 0, 4'hA, 1, 0, 0, 0, 56'hFF_FF_FF_FF_FF_FF_FF), -1, 0);
		add_row(mk(FUNC_LONG_VANE, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0), 1, {8'h10, 24'h0});
		add_row(mk(FUNC_SHORT_VANE, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0), 1,
			{OP_SHORT_VANE | 8'h10, 24'h0});
		add_row(mk(FUNC_SHORT_VANE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0), 1,
			{OP_SHORT_VANE, 24'h0});
		add_row(mk(FUNC_UNUSED_LO, 200, 0, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(mk(FUNC_UNUSED_HI, 255, 4'hF, 4'hF, 1, 511, 32'hFFFF_FFFF, 7, '1), 0, 0);
		add_row(mk(FUNC_END_TILE, 0, 0, 0, 0, 0, 0, 0, 0), 1, {OP_END_TILE, 24'h0});
		add_row(mk(FUNC_END_TILE, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
		add_row(mk(FUNC_SECTOR, 255, 4'hA, 4'h5, 0, 90, 0, 0, 0), -1, 0);
		add_row(mk(FUNC_CIRCLE, 255, 4'hF, 4'hF, 1, 0, 0, 0, 0), 2, {OP_CIRCLE, 8'hFF, 16'h0});
		add_row(mk(FUNC_END_TILE, 0, 0, 0, 0, 0, 0, 0, 0), 1, {OP_END_TILE, 24'h0});
		add_row(mk(FUNC_MULTI, 255, 0, 0, 0, 0, 0, 0, 0), 3,
			{PRE_LONG, 8'hFF, OP_MULTI, 8'h00});
		add_row(mk(FUNC_END_TILE, 0, 0, 0, 0, 0, 0, 0, 0), 1, {OP_END_TILE, 24'h0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].it, dir_rows[i].nexp, dir_rows[i].word);

		hold_req = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= QUIET_AFTER)
				idle_on = 1'b0;
			random_tile();
		end
		item_valid <= 1'b0;

		while (exp_stream.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d items in %0d tiles, %0d bytes checked", items_sent, tiles_sent,
			bytes_checked);
		$display("all skip forms, opcodes and vanes covered, with one long output stall");
		if (fails == 0 && exp_stream.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
